[rtl/xsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsc_pkg: shared types and constants for the XY squareness check
// Word formats, per-chain sideband structs, divide-by-constant factors and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package xsc_pkg;

  // Field and datapath widths.
  localparam int SideW    = 22;
  localparam int SumW     = 45;
  localparam int DiagDW   = 24;
  localparam int DiagW    = 20;
  localparam int Root1W   = 23;
  localparam int FracW    = 30;
  localparam int QW       = 31;
  localparam int Root2W   = 31;
  localparam int CordW    = 33;
  localparam int AngW     = 36;
  localparam int FineW    = 35;
  localparam int SkewW    = 21;
  localparam int DivSteps = 30;
  localparam int CordSteps = 31;

  // Divide by ten: multiply by the rounded-up reciprocal and shift.
  localparam logic [24:0] DivTenMul   = 25'd26843546;
  localparam int          DivTenShift = 28;
  // Divide by 625 after a shift by four gives a divide by 10000.
  localparam logic [31:0] Div625Mul   = 32'd3518437209;
  localparam int          Div625Shift = 41;

  localparam logic [FineW-1:0] RoundHalf   = 35'd5000;
  localparam logic [FineW-1:0] SquareLimit = 35'd10000000;
  localparam logic [SkewW-1:0] AngleMax    = 21'd900000;
  localparam logic [DiagW-1:0] ThrMetric   = 20'd200;
  localparam logic [DiagW-1:0] ThrInch     = 20'd7;

  typedef enum logic [1:0] {
    VerdictSquare = 2'd0,
    VerdictSlight = 2'd1,
    VerdictAdjust = 2'd2
  } verdict_t;

  // Sideband carried through the diagonal square-root chain.
  typedef struct packed {
    logic [SideW-1:0] c;
    logic [SumW-1:0]  mag;
    logic [SumW-1:0]  den;
    logic             neg;
  } sq1_side_t;

  // Sideband carried through the divider chain.
  typedef struct packed {
    logic              neg;
    logic              ang_ok;
    logic              one;
    logic [DiagDW-1:0] d;
  } div_side_t;

  // Sideband carried through the cosine-vector square-root chain.
  typedef struct packed {
    logic [QW-1:0]    q;
    logic             neg;
    logic             ang_ok;
    logic [DiagW-1:0] diag;
  } sq2_side_t;

  // Sideband carried through the CORDIC chain.
  typedef struct packed {
    logic             neg;
    logic             ang_ok;
    logic [DiagW-1:0] diag;
  } cor_side_t;

  // atan(2^-i) in 1e-8 degree, rounded to nearest.
  function automatic logic signed [AngW-1:0] cordic_atan(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0:  v = 36'sd4500000000;
      1:  v = 36'sd2656505118;
      2:  v = 36'sd1403624347;
      3:  v = 36'sd712501635;
      4:  v = 36'sd357633437;
      5:  v = 36'sd178991061;
      6:  v = 36'sd89517371;
      7:  v = 36'sd44761417;
      8:  v = 36'sd22381050;
      9:  v = 36'sd11190568;
      10: v = 36'sd5595289;
      11: v = 36'sd2797645;
      12: v = 36'sd1398823;
      13: v = 36'sd699411;
      14: v = 36'sd349706;
      15: v = 36'sd174853;
      16: v = 36'sd87426;
      17: v = 36'sd43713;
      18: v = 36'sd21857;
      19: v = 36'sd10928;
      20: v = 36'sd5464;
      21: v = 36'sd2732;
      22: v = 36'sd1366;
      23: v = 36'sd683;
      24: v = 36'sd342;
      25: v = 36'sd171;
      26: v = 36'sd85;
      27: v = 36'sd43;
      28: v = 36'sd21;
      29: v = 36'sd11;
      30: v = 36'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/xsc_sqrt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsc_sqrt_cell: one digit of a pipelined integer square root
// Brings down two radicand bits, tries the next root bit and registers the
// partial root, partial remainder and the sideband word.
// ----------------------------------------------------------------------------
module xsc_sqrt_cell #(
  parameter int RW = 23,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [RW+1:0]   rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 vld_o,
  output logic [2*RW-1:0]      rad_o,
  output logic [RW+1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          ge;

  // Trial subtraction for this root digit.
  always_comb begin
    rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_o  <= {rad_i[2*RW-3:0], 2'b00};
    rem_o  <= ge ? (rem_sh - trial) : rem_sh;
    root_o <= {root_i[RW-2:0], ge};
    side_o <= side_i;
  end

endmodule
`default_nettype wire

[rtl/xsc_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsc_div_cell: one quotient bit of a pipelined restoring divider
// Doubles the partial remainder, compares it with the divisor and shifts the
// new bit into the quotient.
// ----------------------------------------------------------------------------
module xsc_div_cell #(
  parameter int DW = 45,
  parameter int QB = 30,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic [DW:0]   rem_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [QB-1:0] q_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [DW:0]        rem_o,
  output logic [DW-1:0]      den_o,
  output logic [QB-1:0]      q_o,
  output logic [SW-1:0]      side_o
);

  logic [DW:0] rem_sh;
  logic [DW:0] den_ext;
  logic        ge;

  // Compare the doubled remainder against the divisor.
  always_comb begin
    rem_sh  = {rem_i[DW-1:0], 1'b0};
    den_ext = {1'b0, den_i};
    ge      = (rem_sh >= den_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o  <= ge ? (rem_sh - den_ext) : rem_sh;
    den_o  <= den_i;
    q_o    <= {q_i[QB-2:0], ge};
    side_o <= side_i;
  end

endmodule
`default_nettype wire

[rtl/xsc_cordic_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xsc_cordic_cell: one vectoring rotation of the CORDIC chain
// Rotates the vector toward the x axis by atan(2^-I) and accumulates the
// angle; shifts of negative values truncate toward zero.
// ----------------------------------------------------------------------------
module xsc_cordic_cell #(
  parameter int I  = 0,
  parameter int SW = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              vld_i,
  input  wire logic signed [xsc_pkg::CordW-1:0]  x_i,
  input  wire logic signed [xsc_pkg::CordW-1:0]  y_i,
  input  wire logic signed [xsc_pkg::AngW-1:0]   z_i,
  input  wire logic [SW-1:0]                     side_i,
  output logic                                   vld_o,
  output logic signed [xsc_pkg::CordW-1:0]       x_o,
  output logic signed [xsc_pkg::CordW-1:0]       y_o,
  output logic signed [xsc_pkg::AngW-1:0]        z_o,
  output logic [SW-1:0]                          side_o
);
  import xsc_pkg::*;

  localparam logic signed [AngW-1:0] Atan = cordic_atan(I);

  logic signed [CordW-1:0] ny;
  logic signed [CordW-1:0] nx;
  logic signed [CordW-1:0] dx;
  logic signed [CordW-1:0] dy;

  // Magnitude shifts, sign restored afterwards.
  always_comb begin
    ny = -y_i;
    nx = -x_i;
    dx = y_i[CordW-1] ? -(ny >>> I) : (y_i >>> I);
    dy = x_i[CordW-1] ? -(nx >>> I) : (x_i >>> I);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!y_i[CordW-1]) begin
      x_o <= x_i + dx;
      y_o <= y_i - dy;
      z_o <= z_i + Atan;
    end else begin
      x_o <= x_i - dx;
      y_o <= y_i + dy;
      z_o <= z_i - Atan;
    end
    side_o <= side_i;
  end

endmodule
`default_nettype wire

[rtl/xy_squareness_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xy_squareness_check: law-of-cosines squareness check, fully pipelined
// Takes legs a, b and diagonal c and reports the skew angle, the diagonal
// error and a squareness verdict.
// ----------------------------------------------------------------------------
// Usage:
//   A triangle word is taken on a rising edge where start is high and busy is
//   low. busy is always low: the pipeline takes one word every cycle.
//   Each result word appears on the out_ ports for exactly one cycle, marked
//   by out_valid. Results leave in the order the triangles came in.
//   The pipeline is made of the cell chains: 23 cells of the diagonal square
//   root, 30 cells of the cosine divider, 31 cells of the cosine-vector
//   square root and 31 CORDIC cells, plus front and back stages of
//   multiplication and rounding.
//   The receiver cannot stall the block, so nothing ever waits inside it.
//   cfg_we with cfg_metric_units selects the diagonal threshold (1 metric,
//   0 imperial); write it only while no triangle is in flight.
//   Synchronous reset empties the pipeline and selects metric units.
// ----------------------------------------------------------------------------
module xy_squareness_check (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [xsc_pkg::SideW-1:0]    in_side_a,
  input  wire logic [xsc_pkg::SideW-1:0]    in_side_b,
  input  wire logic [xsc_pkg::SideW-1:0]    in_side_c,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_metric_units,
  output logic                              out_valid,
  output logic signed [xsc_pkg::SkewW-1:0]  out_skew_angle,
  output logic                              out_angle_valid,
  output logic [xsc_pkg::DiagW-1:0]         out_diagonal_error,
  output logic [1:0]                        out_verdict
);
  import xsc_pkg::*;

  localparam int Sq1W = $bits(sq1_side_t);
  localparam int DivW = $bits(div_side_t);
  localparam int Sq2W = $bits(sq2_side_t);
  localparam int CorW = $bits(cor_side_t);

  // Configuration register.
  logic metric_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= 1'b1;
    end else if (cfg_we) begin
      metric_r <= cfg_metric_units;
    end
  end

  assign busy = 1'b0;

  // Input stage.
  logic             v1_r;
  logic [SideW-1:0] a_r, b_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= in_side_a;
    b_r  <= in_side_b;
    c1_r <= in_side_c;
  end

  // Squares and the leg product.
  logic               v2_r;
  logic [2*SideW-1:0] asq_r, bsq_r, csq_r, ab_r;
  logic [SideW-1:0]   c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    asq_r <= a_r * a_r;
    bsq_r <= b_r * b_r;
    csq_r <= c1_r * c1_r;
    ab_r  <= a_r * b_r;
    c2_r  <= c1_r;
  end

  // Sum of squares, cosine numerator magnitude and denominator.
  logic            v3_r;
  logic [SumW-1:0] sum_r;
  sq1_side_t       s3_r;
  logic [SumW-1:0] sum_nxt;
  logic [SumW-1:0] csq_ext;

  always_comb begin
    sum_nxt = {1'b0, asq_r} + {1'b0, bsq_r};
    csq_ext = {1'b0, csq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    s3_r.c   <= c2_r;
    s3_r.neg <= (sum_nxt < csq_ext);
    s3_r.mag <= (sum_nxt < csq_ext) ? (csq_ext - sum_nxt) : (sum_nxt - csq_ext);
    s3_r.den <= {ab_r, 1'b0};
  end

  // Diagonal square-root chain.
  logic                vq1 [0:Root1W];
  logic [2*Root1W-1:0] rad1 [0:Root1W];
  logic [Root1W+1:0]   rem1 [0:Root1W];
  logic [Root1W-1:0]   root1 [0:Root1W];
  logic [Sq1W-1:0]     side1 [0:Root1W];

  assign vq1[0]   = v3_r;
  assign rad1[0]  = {1'b0, sum_r};
  assign rem1[0]  = '0;
  assign root1[0] = '0;
  assign side1[0] = s3_r;

  for (genvar g = 0; g < Root1W; g++) begin : g_sq1
    xsc_sqrt_cell #(.RW(Root1W), .SW(Sq1W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vq1[g]),
      .rad_i (rad1[g]),
      .rem_i (rem1[g]),
      .root_i(root1[g]),
      .side_i(side1[g]),
      .vld_o (vq1[g+1]),
      .rad_o (rad1[g+1]),
      .rem_o (rem1[g+1]),
      .root_o(root1[g+1]),
      .side_o(side1[g+1])
    );
  end

  // Diagonal difference before the divide by ten, and cosine range checks.
  sq1_side_t         s4;
  logic [DiagDW-1:0] up;
  logic [DiagDW-1:0] d_nxt;
  logic              v4_r;
  div_side_t         s4_r;
  logic [SumW:0]     rem4_r;
  logic [SumW-1:0]   den4_r;

  always_comb begin
    s4 = sq1_side_t'(side1[Root1W]);
    up = {1'b0, root1[Root1W]} + {{(DiagDW-1){1'b0}}, (rem1[Root1W] != '0)};
    if (!s4.neg) begin
      d_nxt = {1'b0, root1[Root1W]} - {2'b0, s4.c} + DiagDW'(5);
    end else begin
      d_nxt = {2'b0, s4.c} + DiagDW'(5) - up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vq1[Root1W];
    end
  end

  always_ff @(posedge clk) begin
    s4_r.neg    <= s4.neg;
    s4_r.ang_ok <= (s4.den != '0) && (s4.mag <= s4.den);
    s4_r.one    <= (s4.mag == s4.den);
    s4_r.d      <= d_nxt;
    rem4_r      <= {1'b0, s4.mag};
    den4_r      <= s4.den;
  end

  // Cosine divider chain.
  logic            vdv [0:DivSteps];
  logic [SumW:0]   remd [0:DivSteps];
  logic [SumW-1:0] dend [0:DivSteps];
  logic [FracW-1:0] qd  [0:DivSteps];
  logic [DivW-1:0] sided [0:DivSteps];

  assign vdv[0]   = v4_r;
  assign remd[0]  = rem4_r;
  assign dend[0]  = den4_r;
  assign qd[0]    = '0;
  assign sided[0] = s4_r;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    xsc_div_cell #(.DW(SumW), .QB(FracW), .SW(DivW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vdv[g]),
      .rem_i (remd[g]),
      .den_i (dend[g]),
      .q_i   (qd[g]),
      .side_i(sided[g]),
      .vld_o (vdv[g+1]),
      .rem_o (remd[g+1]),
      .den_o (dend[g+1]),
      .q_o   (qd[g+1]),
      .side_o(sided[g+1])
    );
  end

  // Square of the cosine and the divide-by-ten product.
  div_side_t         s6;
  logic [QW-1:0]     q_full;
  logic              v6_r;
  logic [QW-1:0]     q6_r;
  logic [2*QW-1:0]   qsq_r;
  logic [DiagDW+24:0] diagp_r;
  logic              neg6_r, ok6_r;

  always_comb begin
    s6     = div_side_t'(sided[DivSteps]);
    q_full = s6.one ? (QW'(1) << FracW) : {1'b0, qd[DivSteps]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= vdv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    q6_r    <= q_full;
    qsq_r   <= q_full * q_full;
    diagp_r <= s6.d * DivTenMul;
    neg6_r  <= s6.neg;
    ok6_r   <= s6.ang_ok;
  end

  // Radicand of the cosine-vector x component.
  logic              v7_r;
  logic [2*Root2W-1:0] rad7_r;
  sq2_side_t         s7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    rad7_r      <= ((2*Root2W)'(1) << (2*FracW)) - qsq_r;
    s7_r.q      <= q6_r;
    s7_r.neg    <= neg6_r;
    s7_r.ang_ok <= ok6_r;
    s7_r.diag   <= diagp_r[DivTenShift +: DiagW];
  end

  // Cosine-vector square-root chain.
  logic                vq2 [0:Root2W];
  logic [2*Root2W-1:0] rad2 [0:Root2W];
  logic [Root2W+1:0]   rem2 [0:Root2W];
  logic [Root2W-1:0]   root2 [0:Root2W];
  logic [Sq2W-1:0]     side2 [0:Root2W];

  assign vq2[0]   = v7_r;
  assign rad2[0]  = rad7_r;
  assign rem2[0]  = '0;
  assign root2[0] = '0;
  assign side2[0] = s7_r;

  for (genvar g = 0; g < Root2W; g++) begin : g_sq2
    xsc_sqrt_cell #(.RW(Root2W), .SW(Sq2W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vq2[g]),
      .rad_i (rad2[g]),
      .rem_i (rem2[g]),
      .root_i(root2[g]),
      .side_i(side2[g]),
      .vld_o (vq2[g+1]),
      .rad_o (rad2[g+1]),
      .rem_o (rem2[g+1]),
      .root_o(root2[g+1]),
      .side_o(side2[g+1])
    );
  end

  // CORDIC vectoring chain, starting from (sqrt(1-q^2), q).
  sq2_side_t               s8;
  cor_side_t               c8;
  logic                    vcr [0:CordSteps];
  logic signed [CordW-1:0] xc [0:CordSteps];
  logic signed [CordW-1:0] yc [0:CordSteps];
  logic signed [AngW-1:0]  zc [0:CordSteps];
  logic [CorW-1:0]         sidec [0:CordSteps];

  always_comb begin
    s8        = sq2_side_t'(side2[Root2W]);
    c8.neg    = s8.neg;
    c8.ang_ok = s8.ang_ok;
    c8.diag   = s8.diag;
  end

  assign vcr[0]   = vq2[Root2W];
  assign xc[0]    = {{(CordW-Root2W){1'b0}}, root2[Root2W]};
  assign yc[0]    = {{(CordW-QW){1'b0}}, s8.q};
  assign zc[0]    = '0;
  assign sidec[0] = c8;

  for (genvar g = 0; g < CordSteps; g++) begin : g_cor
    xsc_cordic_cell #(.I(g), .SW(CorW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vcr[g]),
      .x_i   (xc[g]),
      .y_i   (yc[g]),
      .z_i   (zc[g]),
      .side_i(sidec[g]),
      .vld_o (vcr[g+1]),
      .x_o   (xc[g+1]),
      .y_o   (yc[g+1]),
      .z_o   (zc[g+1]),
      .side_o(sidec[g+1])
    );
  end

  // Clamp the fine angle, add the rounding half and test for square.
  cor_side_t        cf;
  logic [FineW-1:0] fine;
  logic [FineW:0]   fine_rnd;
  logic             vf1_r;
  logic [31:0]      t_r;
  logic             sq_r;
  cor_side_t        f1_r;

  always_comb begin
    cf       = cor_side_t'(sidec[CordSteps]);
    fine     = zc[CordSteps][AngW-1] ? '0 : zc[CordSteps][FineW-1:0];
    fine_rnd = {1'b0, fine} + {1'b0, RoundHalf};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
    end else begin
      vf1_r <= vcr[CordSteps];
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= fine_rnd[35:4];
    sq_r <= cf.ang_ok && (fine < SquareLimit);
    f1_r <= cf;
  end

  // Divide by 625 as a reciprocal product.
  logic        vf2_r;
  logic [63:0] p_r;
  logic        sq2_r;
  cor_side_t   f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf2_r <= 1'b0;
    end else begin
      vf2_r <= vf1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= t_r * Div625Mul;
    sq2_r <= sq_r;
    f2_r  <= f1_r;
  end

  // Saturate, sign the angle and form the verdict.
  logic [22:0]      s_raw;
  logic [SkewW-1:0] s_mag;
  logic [SkewW-1:0] skew_nxt;
  logic [DiagW-1:0] thr;
  verdict_t         verdict_nxt;

  always_comb begin
    s_raw = p_r[Div625Shift +: 23];
    s_mag = (s_raw > {2'b0, AngleMax}) ? AngleMax : s_raw[SkewW-1:0];
    if (!f2_r.ang_ok) begin
      skew_nxt = '0;
    end else if (f2_r.neg) begin
      skew_nxt = -s_mag;
    end else begin
      skew_nxt = s_mag;
    end
    thr = metric_r ? ThrMetric : ThrInch;
    if (sq2_r) begin
      verdict_nxt = VerdictSquare;
    end else if (f2_r.diag <= thr) begin
      verdict_nxt = VerdictSlight;
    end else begin
      verdict_nxt = VerdictAdjust;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vf2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_skew_angle     <= skew_nxt;
    out_angle_valid    <= f2_r.ang_ok;
    out_diagonal_error <= f2_r.diag;
    out_verdict        <= verdict_nxt;
  end

endmodule
`default_nettype wire
